FILE: sv/sptwa_pkg.sv
// Package for the station probe table: words, chain token, broadcast buses, codes.
// Used by sptwa_cell and station_probe_table_with_aging_core; no dependencies.
package sptwa_pkg;

  localparam int ENTRIES_DEFAULT = 32;
  localparam int READ_SLOTS      = 32;

  localparam logic [7:0]  CHAN_SPLIT   = 8'd14;
  localparam logic [7:0]  LEVEL_OFFSET = 8'd100;

  localparam logic [15:0] STALE_LIMIT_RESET    = 16'd60;
  localparam logic [15:0] CHECK_INTERVAL_RESET = 16'd5;

  localparam logic [1:0] ACT_OBSERVE = 2'd0;
  localparam logic [1:0] ACT_TICK    = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;
  localparam logic [1:0] ACT_READ    = 2'd3;

  localparam logic REG_STALE_LIMIT    = 1'b0;
  localparam logic REG_CHECK_INTERVAL = 1'b1;

  typedef struct packed {
    logic [1:0]  action;
    logic [47:0] station_mac;
    logic [6:0]  signal_level;
    logic [7:0]  channel_number;
    logic        from_access_point;
    logic [4:0]  mode_bits;
    logic        band_select;
    logic [4:0]  read_slot;
  } in_word_t;

  typedef struct packed {
    logic              was_known;
    logic              was_inserted;
    logic [4:0]        entry_slot;
    logic [5:0]        band_count;
    logic              entry_valid;
    logic [47:0]       entry_address;
    logic signed [7:0] entry_level;
    logic              entry_is_ap;
    logic [4:0]        entry_modes;
    logic [7:0]        last_channel;
  } out_word_t;

  // token that walks the cell chain, one cell per cycle
  typedef struct packed {
    logic        valid;
    logic [1:0]  op;
    logic        band;
    logic        sweep;
    logic [47:0] mac;
    logic [4:0]  rslot;
    logic        found;
    logic        free_found;
    logic        rd_valid;
    logic [47:0] rd_addr;
    logic [7:0]  rd_level;
    logic        rd_ap;
    logic [4:0]  rd_modes;
  } tok_t;

  // values every cell sees
  typedef struct packed {
    logic [31:0] now_time;
    logic [15:0] stale_limit;
  } bcast_t;

  // slot write issued at the end of an observe miss
  typedef struct packed {
    logic        valid;
    logic        band;
    logic [47:0] mac;
    logic [7:0]  level;
    logic        ap;
    logic [4:0]  modes;
  } wr_t;

endpackage

FILE: sv/sptwa_cell.sv
// One table cell: holds slot IDX of both bands and passes the token on each cycle.
// Depends on sptwa_pkg (tok_t, bcast_t, wr_t, action codes).
module sptwa_cell #(
  parameter int ENTRIES = sptwa_pkg::ENTRIES_DEFAULT,
  parameter int IDX     = 0,
  localparam int SLOT_W = $clog2(ENTRIES),
  localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  sptwa_pkg::bcast_t   bc,
  input  sptwa_pkg::wr_t      wr,
  input  logic [SLOT_W-1:0]   wr_idx,
  input  sptwa_pkg::tok_t     tok_in,
  input  logic [SLOT_W-1:0]   hit_in,
  input  logic [SLOT_W-1:0]   free_in,
  input  logic [CNT_W-1:0]    ev0_in,
  input  logic [CNT_W-1:0]    ev1_in,
  output sptwa_pkg::tok_t     tok_out,
  output logic [SLOT_W-1:0]   hit_out,
  output logic [SLOT_W-1:0]   free_out,
  output logic [CNT_W-1:0]    ev0_out,
  output logic [CNT_W-1:0]    ev1_out
);

  localparam logic READABLE = (IDX < sptwa_pkg::READ_SLOTS);

  logic [1:0]       used;
  logic [47:0]      addr  [2];
  logic [7:0]       level [2];
  logic [1:0]       ap;
  logic [4:0]       modes [2];
  logic [31:0]      stamp [2];

  sptwa_pkg::tok_t   tok_next;
  logic              b;
  logic              is_obs;
  logic              hit;
  logic              free;
  logic              do_sweep;
  logic              do_clear;
  logic              rd_hit;
  logic [1:0]        stale;
  logic              wr_here;

  always_comb begin
    b        = tok_in.band;
    is_obs   = tok_in.valid && (tok_in.op == sptwa_pkg::ACT_OBSERVE);
    hit      = is_obs && !tok_in.found && used[b] && (addr[b] == tok_in.mac);
    free     = is_obs && !tok_in.free_found && !used[b];
    do_sweep = tok_in.valid && (tok_in.op == sptwa_pkg::ACT_TICK) && tok_in.sweep;
    do_clear = tok_in.valid && (tok_in.op == sptwa_pkg::ACT_CLEAR);
    rd_hit   = tok_in.valid && (tok_in.op == sptwa_pkg::ACT_READ) && READABLE &&
               (tok_in.rslot == 5'(IDX)) && used[b];
    for (int j = 0; j < 2; j++) begin
      // wraparound age, compared against the zero-extended timeout
      stale[j] = used[j] && ((bc.now_time - stamp[j]) > {16'd0, bc.stale_limit});
    end
    wr_here = wr.valid && (wr_idx == SLOT_W'(IDX));

    tok_next = tok_in;
    if (hit) tok_next.found = 1'b1;
    if (free) tok_next.free_found = 1'b1;
    if (rd_hit) begin
      tok_next.rd_valid = 1'b1;
      tok_next.rd_addr  = addr[b];
      tok_next.rd_level = level[b];
      tok_next.rd_ap    = ap[b];
      tok_next.rd_modes = modes[b];
    end
    if (rst) tok_next.valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    tok_out  <= tok_next;
    hit_out  <= hit  ? SLOT_W'(IDX) : hit_in;
    free_out <= free ? SLOT_W'(IDX) : free_in;
    ev0_out  <= (do_sweep && stale[0]) ? CNT_W'(ev0_in + 1'b1) : ev0_in;
    ev1_out  <= (do_sweep && stale[1]) ? CNT_W'(ev1_in + 1'b1) : ev1_in;
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 2; j++) begin
      if (rst) begin
        used[j] <= 1'b0;
      end else if (wr_here && (wr.band == j[0])) begin
        used[j]  <= 1'b1;
        addr[j]  <= wr.mac;
        level[j] <= wr.level;
        ap[j]    <= wr.ap;
        modes[j] <= wr.modes;
        stamp[j] <= bc.now_time;
      end else begin
        if (hit && (b == j[0])) stamp[j] <= bc.now_time;
        if ((do_sweep && stale[j]) || (do_clear && (b == j[0]))) used[j] <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/station_probe_table_with_aging_core.sv
// Top level of the station probe table: sequencer, counters and the chain of cells.
// Depends on sptwa_pkg and sptwa_cell.
//
// Usage:
//   in_valid/in_ready/in_data carry one command word (observe, tick, clear band,
//   read entry). out_valid/out_ready/out_data return exactly one result word per
//   command. cfg_valid/cfg_ready/cfg_index/cfg_data write the stale limit (index 0)
//   or check_interval (index 1); cfg_ready is always high, write only when idle.
//   Every command sends a token down a row of ENTRIES cells, one cell per cycle;
//   each cell holds one slot of both bands and does its lookup, refresh, aging,
//   clear or readout as the token passes. out_valid rises once the token has left
//   the last cell and been captured in S_FIN, and in_ready returns at the same
//   time; no new command is accepted while one is still in the chain.
//   A finished result sits in the output register; the next command is still
//   accepted, and it waits at its end until the previous word is taken.
//   Synchronous reset empties both tables at once (valid bits in flip-flops),
//   restores the register defaults and zeroes time and the sweep counter.
module station_probe_table_with_aging_core #(
  parameter int ENTRIES = sptwa_pkg::ENTRIES_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sptwa_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sptwa_pkg::out_word_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int SLOT_W = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]           state;
  sptwa_pkg::in_word_t  item;
  logic                 band;
  logic [31:0]          now_time;
  logic [15:0]          sweep_counter;
  logic [15:0]          stale_limit;
  logic [15:0]          check_interval;
  logic [CNT_W-1:0]     used_count      [2];
  logic [SLOT_W-1:0]    replace_pointer [2];
  logic [7:0]           insert_channel  [2];

  sptwa_pkg::tok_t      launch_tok;
  sptwa_pkg::tok_t      fin_tok;
  logic [SLOT_W-1:0]    fin_hit;
  logic [SLOT_W-1:0]    fin_free;
  logic [CNT_W-1:0]     fin_ev0;
  logic [CNT_W-1:0]     fin_ev1;

  sptwa_pkg::tok_t      tok_chain  [ENTRIES+1];
  logic [SLOT_W-1:0]    hit_chain  [ENTRIES+1];
  logic [SLOT_W-1:0]    free_chain [ENTRIES+1];
  logic [CNT_W-1:0]     ev0_chain  [ENTRIES+1];
  logic [CNT_W-1:0]     ev1_chain  [ENTRIES+1];

  sptwa_pkg::bcast_t    bc;
  sptwa_pkg::wr_t       wr_pre;
  sptwa_pkg::wr_t       wr_bus;
  logic [SLOT_W-1:0]    wr_idx;
  sptwa_pkg::out_word_t res;
  logic [CNT_W-1:0]     cnt_next [2];
  logic [SLOT_W-1:0]    rp_next  [2];
  logic [7:0]           ic_next  [2];

  logic                 accept;
  logic                 fin_go;
  logic                 in_band;
  logic [15:0]          sc_inc;
  logic                 sweep_now;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign fin_go    = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    in_band   = (in_data.action == sptwa_pkg::ACT_OBSERVE) ?
                (in_data.channel_number > sptwa_pkg::CHAN_SPLIT) : in_data.band_select;
    sc_inc    = sweep_counter + 16'd1;
    sweep_now = (sc_inc >= check_interval);
  end

  assign bc.now_time    = now_time;
  assign bc.stale_limit = stale_limit;

  // chain head
  assign tok_chain[0]  = launch_tok;
  assign hit_chain[0]  = '0;
  assign free_chain[0] = '0;
  assign ev0_chain[0]  = '0;
  assign ev1_chain[0]  = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    sptwa_cell #(
      .ENTRIES (ENTRIES),
      .IDX     (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .bc       (bc),
      .wr       (wr_bus),
      .wr_idx   (wr_idx),
      .tok_in   (tok_chain[i]),
      .hit_in   (hit_chain[i]),
      .free_in  (free_chain[i]),
      .ev0_in   (ev0_chain[i]),
      .ev1_in   (ev1_chain[i]),
      .tok_out  (tok_chain[i+1]),
      .hit_out  (hit_chain[i+1]),
      .free_out (free_chain[i+1]),
      .ev0_out  (ev0_chain[i+1]),
      .ev1_out  (ev1_chain[i+1])
    );
  end

  // end-of-command bookkeeping and result word
  always_comb begin
    cnt_next = used_count;
    rp_next  = replace_pointer;
    ic_next  = insert_channel;
    res      = '0;
    wr_idx   = '0;
    wr_pre.valid = 1'b0;
    wr_pre.band  = band;
    wr_pre.mac   = item.station_mac;
    wr_pre.level = 8'({1'b0, item.signal_level}) - sptwa_pkg::LEVEL_OFFSET;
    wr_pre.ap    = item.from_access_point;
    wr_pre.modes = item.from_access_point ? item.mode_bits : 5'd0;
    case (item.action)
      sptwa_pkg::ACT_OBSERVE: begin
        if (fin_tok.found) begin
          res.was_known  = 1'b1;
          res.entry_slot = 5'(fin_hit);
        end else begin
          ic_next[band] = item.channel_number;
          if (used_count[band] >= CNT_W'(ENTRIES)) begin
            // full band: overwrite round-robin
            wr_idx        = replace_pointer[band];
            rp_next[band] = (replace_pointer[band] == SLOT_W'(ENTRIES - 1)) ? '0 :
                            SLOT_W'(replace_pointer[band] + 1'b1);
            wr_pre.valid  = 1'b1;
          end else if (fin_tok.free_found) begin
            wr_idx         = fin_free;
            cnt_next[band] = CNT_W'(used_count[band] + 1'b1);
            wr_pre.valid   = 1'b1;
          end
          if (wr_pre.valid) begin
            res.was_inserted = 1'b1;
            res.entry_slot   = 5'(wr_idx);
          end
        end
      end
      sptwa_pkg::ACT_TICK: begin
        if (fin_tok.sweep) begin
          cnt_next[0] = (fin_ev0 > used_count[0]) ? '0 : CNT_W'(used_count[0] - fin_ev0);
          cnt_next[1] = (fin_ev1 > used_count[1]) ? '0 : CNT_W'(used_count[1] - fin_ev1);
        end
      end
      sptwa_pkg::ACT_CLEAR: begin
        cnt_next[band] = '0;
        rp_next[band]  = '0;
      end
      default: begin
        res.entry_valid   = fin_tok.rd_valid;
        res.entry_address = fin_tok.rd_addr;
        res.entry_level   = $signed(fin_tok.rd_level);
        res.entry_is_ap   = fin_tok.rd_ap;
        res.entry_modes   = fin_tok.rd_modes;
      end
    endcase
    res.band_count   = 6'(cnt_next[band]);
    res.last_channel = ic_next[band];
  end

  always_comb begin
    wr_bus       = wr_pre;
    wr_bus.valid = wr_pre.valid && fin_go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      launch_tok      <= '0;
      now_time        <= '0;
      sweep_counter   <= '0;
      stale_limit     <= sptwa_pkg::STALE_LIMIT_RESET;
      check_interval  <= sptwa_pkg::CHECK_INTERVAL_RESET;
      for (int j = 0; j < 2; j++) begin
        used_count[j]      <= '0;
        replace_pointer[j] <= '0;
        insert_channel[j]  <= '0;
      end
    end else begin
      launch_tok.valid <= accept;

      if (cfg_valid) begin
        case (cfg_index)
          sptwa_pkg::REG_STALE_LIMIT:    stale_limit    <= cfg_data;
          sptwa_pkg::REG_CHECK_INTERVAL: check_interval <= cfg_data;
          default: ;
        endcase
      end

      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            item <= in_data;
            band <= in_band;
            launch_tok.op         <= in_data.action;
            launch_tok.band       <= in_band;
            launch_tok.mac        <= in_data.station_mac;
            launch_tok.rslot      <= in_data.read_slot;
            launch_tok.sweep      <= sweep_now;
            if (in_data.action == sptwa_pkg::ACT_TICK) begin
              now_time      <= now_time + 32'd1;
              sweep_counter <= sweep_now ? 16'd0 : sc_inc;
            end
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (tok_chain[ENTRIES].valid) begin
            fin_tok  <= tok_chain[ENTRIES];
            fin_hit  <= hit_chain[ENTRIES];
            fin_free <= free_chain[ENTRIES];
            fin_ev0  <= ev0_chain[ENTRIES];
            fin_ev1  <= ev1_chain[ENTRIES];
            state    <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            used_count      <= cnt_next;
            replace_pointer <= rp_next;
            insert_channel  <= ic_next;
            out_data        <= res;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
